// ===== hw/rtl/rpf_pkg.sv =====
// Shared types, register indexes, mode codes and reset values of the prediction filter
package rpf_pkg;

    localparam int MAX_WIDTH_DEF = 1024;

    localparam int PIX_W  = 8;
    localparam int MODE_W = 2;
    localparam int LW_W   = 11;
    localparam int CFG_W  = 11;
    localparam int IDX_W  = 1;

    // register indexes of the write port
    localparam logic [IDX_W-1:0] REG_FILTER_MODE = 1'd0;
    localparam logic [IDX_W-1:0] REG_LINE_WIDTH  = 1'd1;

    // filter modes
    localparam logic [MODE_W-1:0] MODE_VERT_XOR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HORZ_XOR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MED      = 2'd2;

    localparam logic [MODE_W-1:0] MODE_RESET = MODE_MED;
    localparam logic [LW_W-1:0]   LW_RESET   = 11'd640;

    typedef logic [PIX_W-1:0] pix_t;

    // neighborhood and position of one pixel at the predictor
    typedef struct packed {
        pix_t px;
        pix_t left;
        pix_t upper_left;
        pix_t above;
        logic first_pixel;
        logic first_row;
        logic col_zero;
    } ctx_t;

endpackage

// ===== hw/rtl/rpf_pix_if.sv =====
// Input channel: one raster pixel per beat
interface rpf_pix_if;
    logic                 valid;
    logic                 ready;
    logic [rpf_pkg::PIX_W-1:0] pixel;
    logic                 last_of_frame;

    modport source (output valid, output pixel, output last_of_frame, input ready);
    modport sink   (input valid, input pixel, input last_of_frame, output ready);
endinterface

// ===== hw/rtl/rpf_res_if.sv =====
// Output channel: one filtered byte per beat
interface rpf_res_if;
    logic                      valid;
    logic                      ready;
    logic [rpf_pkg::PIX_W-1:0] filtered;

    modport source (output valid, output filtered, input ready);
    modport sink   (input valid, input filtered, output ready);
endinterface

// ===== hw/rtl/rpf_line_buf.sv =====
// Line buffer of the previous row: one write and one registered read port
module rpf_line_buf #(
    parameter int DEPTH = rpf_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output rpf_pkg::pix_t       rd_data,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  rpf_pkg::pix_t       wr_data
);

    rpf_pkg::pix_t mem [DEPTH];
    rpf_pkg::pix_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // hold the read data until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/rpf_predict.sv =====
// Predictor and residual: XOR modes and median edge residual; other mode codes pass the pixel through
module rpf_predict (
    input  logic [rpf_pkg::MODE_W-1:0] mode,
    input  rpf_pkg::ctx_t              ctx,
    output rpf_pkg::pix_t              filtered
);

    rpf_pkg::pix_t lo;
    rpf_pkg::pix_t hi;
    rpf_pkg::pix_t med;
    rpf_pkg::pix_t pred;

    always_comb
    begin
        lo = (ctx.left < ctx.above) ? ctx.left : ctx.above;
        hi = (ctx.left > ctx.above) ? ctx.left : ctx.above;
        if (ctx.upper_left >= hi)
        begin
            med = lo;
        end
        else if (ctx.upper_left <= lo)
        begin
            med = hi;
        end
        else
        begin
            med = rpf_pkg::pix_t'(ctx.left + ctx.above - ctx.upper_left);
        end

        if (ctx.first_pixel)
        begin
            pred = '0;
        end
        else if (ctx.first_row)
        begin
            pred = ctx.left;
        end
        else if (ctx.col_zero)
        begin
            pred = ctx.above;
        end
        else
        begin
            pred = med;
        end
    end

    always_comb
    begin
        case (mode)
            rpf_pkg::MODE_VERT_XOR:
                filtered = ctx.first_row ? ctx.px : (ctx.px ^ ctx.above);
            rpf_pkg::MODE_HORZ_XOR:
                filtered = ctx.first_pixel ? ctx.px : (ctx.px ^ ctx.left);
            rpf_pkg::MODE_MED:
                filtered = rpf_pkg::pix_t'(ctx.px - pred);
            default:
                filtered = ctx.px;
        endcase
    end

endmodule

// ===== hw/rtl/raster_prediction_filter.sv =====
// Raster prediction filter: one filtered byte per pixel, line buffer of the previous row
// Stages: s1, output register. Back-to-back reuse of a column (one-pixel rows) is forwarded.
// Throughput: one pixel per cycle unless the output stalls; the line buffer is read on accept,
// written when the pixel moves on to the output register.
// Reset: position clears, first-row/first-pixel set, mode 2, width 640; line buffer not cleared.
module raster_prediction_filter #(
    parameter int MAX_WIDTH = rpf_pkg::MAX_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [rpf_pkg::IDX_W-1:0]    wr_index,
    input  logic [rpf_pkg::CFG_W-1:0]    wr_data,
    rpf_pix_if.sink                      pix_in,
    rpf_res_if.source                    res_out
);

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int CW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (CW > rpf_pkg::LW_W) ? CW : rpf_pkg::LW_W;

    // configuration
    logic [rpf_pkg::MODE_W-1:0] mode_reg;
    logic [rpf_pkg::LW_W-1:0]   width_reg;

    // frame position
    logic [AW-1:0]  col_reg;
    logic           first_row_reg;
    logic           first_pixel_reg;
    rpf_pkg::pix_t  left_reg;
    rpf_pkg::pix_t  upper_left_reg;

    // pixel waiting for its line buffer read
    logic           s1_valid_reg;
    rpf_pkg::pix_t  s1_px_reg;
    rpf_pkg::pix_t  s1_left_reg;
    logic [AW-1:0]  s1_col_reg;
    logic           s1_first_row_reg;
    logic           s1_first_pixel_reg;
    logic           s1_last_reg;
    logic           fwd_reg;
    rpf_pkg::pix_t  fwd_data_reg;

    // output register
    logic           out_valid_reg;
    rpf_pkg::pix_t  out_data_reg;

    logic           in_acc;
    logic           s1_adv;
    logic           fwd_next;
    logic [CMPW-1:0] eff_width;
    logic [CMPW-1:0] lw_ext;
    logic [CMPW-1:0] col_inc;
    logic           row_end;
    logic [AW-1:0]  col_next;
    rpf_pkg::pix_t  rd_data;
    rpf_pkg::pix_t  above;
    rpf_pkg::ctx_t  ctx;
    rpf_pkg::pix_t  result;

    assign s1_adv        = s1_valid_reg && (!out_valid_reg || res_out.ready);
    assign pix_in.ready  = !s1_valid_reg || s1_adv;
    assign in_acc        = pix_in.valid && pix_in.ready;

    // effective width: zero acts as one, clamp to the buffer depth
    always_comb
    begin
        lw_ext = CMPW'(width_reg);
        if (width_reg == '0)
        begin
            eff_width = CMPW'(1);
        end
        else if (lw_ext > CMPW'(MAX_WIDTH))
        begin
            eff_width = CMPW'(MAX_WIDTH);
        end
        else
        begin
            eff_width = lw_ext;
        end
        col_inc  = CMPW'(col_reg) + CMPW'(1);
        row_end  = col_inc >= eff_width;
        col_next = row_end ? '0 : col_inc[AW-1:0];
    end

    // the pixel now leaving for the output writes the column about to be read
    assign fwd_next = s1_adv && (s1_col_reg == col_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= rpf_pkg::MODE_RESET;
            width_reg <= rpf_pkg::LW_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                rpf_pkg::REG_FILTER_MODE: mode_reg  <= wr_data[rpf_pkg::MODE_W-1:0];
                rpf_pkg::REG_LINE_WIDTH:  width_reg <= wr_data[rpf_pkg::LW_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg         <= '0;
            first_row_reg   <= 1'b1;
            first_pixel_reg <= 1'b1;
            left_reg        <= '0;
            s1_valid_reg    <= 1'b0;
            fwd_reg         <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                if (pix_in.last_of_frame)
                begin
                    col_reg         <= '0;
                    first_row_reg   <= 1'b1;
                    first_pixel_reg <= 1'b1;
                    left_reg        <= '0;
                end
                else
                begin
                    col_reg         <= col_next;
                    first_row_reg   <= first_row_reg && !row_end;
                    first_pixel_reg <= 1'b0;
                    left_reg        <= pix_in.pixel;
                end
                fwd_reg <= fwd_next;
            end
            if (in_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_px_reg          <= pix_in.pixel;
            s1_left_reg        <= left_reg;
            s1_col_reg         <= col_reg;
            s1_first_row_reg   <= first_row_reg;
            s1_first_pixel_reg <= first_pixel_reg;
            s1_last_reg        <= pix_in.last_of_frame;
            fwd_data_reg       <= s1_px_reg;
        end
    end

    rpf_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line_buf (
        .clk     (clk),
        .rd_en   (in_acc),
        .rd_addr (col_reg),
        .rd_data (rd_data),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (s1_px_reg)
    );

    assign above = fwd_reg ? fwd_data_reg : rd_data;

    always_comb
    begin
        ctx.px          = s1_px_reg;
        ctx.left        = s1_left_reg;
        ctx.upper_left  = upper_left_reg;
        ctx.above       = above;
        ctx.first_pixel = s1_first_pixel_reg;
        ctx.first_row   = s1_first_row_reg;
        ctx.col_zero    = (s1_col_reg == '0);
    end

    rpf_predict u_predict (
        .mode     (mode_reg),
        .ctx      (ctx),
        .filtered (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_left_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                upper_left_reg <= s1_last_reg ? '0 : above;
                out_valid_reg  <= 1'b1;
            end
            else if (res_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_data_reg <= result;
        end
    end

    assign res_out.valid    = out_valid_reg;
    assign res_out.filtered = out_data_reg;

endmodule
